FILE: rtl/rgb_box_downsampler_unit_assert.svh
// assertion macros for the rgb box downsampler
`ifndef RGB_BOX_DOWNSAMPLER_UNIT_ASSERT_SVH
`define RGB_BOX_DOWNSAMPLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RBD_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("rbd check failed");
`define RBD_ASSERT_NXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rbd check failed");
`else
`define RBD_ASSERT_IMP(label, clk, rst, pre, post)
`define RBD_ASSERT_NXT(label, clk, rst, pre, post)
`endif
`endif

FILE: rtl/rbd_pkg.sv
// shared types and constants for the rgb box downsampler
`default_nettype none
package rbd_pkg;

  localparam int DEF_MAX_WIDTH  = 8192;
  localparam int DEF_MAX_HEIGHT = 8192;
  localparam int SAMPLE_W       = 16;
  localparam int CFG_W          = 14;
  localparam int QUOT_W         = 16;
  localparam int IDX_W          = 2;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] BYTE_MAX     = 8'd255;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_SRC_WIDTH    = 2'd0;
  localparam logic [IDX_W-1:0] REG_SRC_HEIGHT   = 2'd1;
  localparam logic [IDX_W-1:0] REG_MAX_DIM      = 2'd2;
  localparam logic [IDX_W-1:0] REG_WIDE_SAMPLES = 2'd3;

  typedef struct packed {
    logic [SAMPLE_W-1:0] red_sample;
    logic [SAMPLE_W-1:0] green_sample;
    logic [SAMPLE_W-1:0] blue_sample;
  } in_item_t;

  typedef struct packed {
    logic [31:0] argb_pixel;
    logic        frame_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic rd;
    logic scale_init;
    logic scale_step;
    logic scale_load;
    logic area_load;
    logic upd;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_start;
    logic blk_ok;
    logic blk_end;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: rtl/rgb_box_downsampler_unit.sv
// rgb box downsampler: averages scale-by-scale pixel blocks into argb pixels
// a pixel goes from accept through the update state before ready again; a block's last
// pixel then adds the 16-step division by the block area and the output load, and its
// output load waits while an earlier output beat still waits on out_ready
// a frame's first pixel adds the scale division and the s*s area load (DW = 14)
// synchronous reset clears counters, scale, output valid and config; line sums are not
`default_nettype none
`include "rgb_box_downsampler_unit_assert.svh"
module rgb_box_downsampler_unit import rbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  localparam int MAX_SIDE = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SCALE_STEPS = $clog2(MAX_SIDE + 1) + 1;

  cmd_t    cmd;
  status_t status;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  rbd_ctrl #(
    .SCALE_STEPS(SCALE_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  rbd_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // checks
  `RBD_ASSERT_IMP(a_load_free, clk, rst, cmd.out_load, status.out_free)
  `RBD_ASSERT_NXT(a_one_pixel, clk, rst, in_valid && in_ready, !in_ready)
  `RBD_ASSERT_IMP(a_one_phase, clk, rst, 1'b1, $onehot0({cmd.scale_step, cmd.div_step, cmd.upd, cmd.rd}))

endmodule
`default_nettype wire

FILE: rtl/rbd_ctrl.sv
// controller state machine of the rgb box downsampler
`default_nettype none
module rbd_ctrl import rbd_pkg::*; #(
  parameter int SCALE_STEPS = 15
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam int MAX_STEPS = (SCALE_STEPS > QUOT_W) ? SCALE_STEPS : QUOT_W;
  localparam int CNT_W     = $clog2(MAX_STEPS);
  localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(SCALE_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(QUOT_W - 1);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SCALE = 7'b0000010,
    ST_SLOAD = 7'b0000100,
    ST_ALOAD = 7'b0001000,
    ST_UPD   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;

  // next state and commands
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.rd = 1'b1;
          if (status.frame_start) begin
            cmd.scale_init = 1'b1;
            cnt_next       = '0;
            state_next     = ST_SCALE;
          end else begin
            state_next = ST_UPD;
          end
        end
      end
      ST_SCALE: begin
        cmd.scale_step = 1'b1;
        cnt_next       = cnt + 1'b1;
        if (cnt == SCALE_LAST) state_next = ST_SLOAD;
      end
      ST_SLOAD: begin
        cmd.scale_load = 1'b1;
        state_next     = ST_ALOAD;
      end
      ST_ALOAD: begin
        cmd.area_load = 1'b1;
        state_next    = ST_UPD;
      end
      ST_UPD: begin
        cmd.upd = 1'b1;
        if (status.blk_ok && status.blk_end) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = ST_DIV;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == DIV_LAST) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/rbd_datapath.sv
// datapath of the rgb box downsampler: config, counters, line sums, dividers
`default_nettype none
module rbd_datapath import rbd_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire in_item_t         in_data,
  input  wire cmd_t             cmd,
  output status_t               status,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data
);

  localparam int MAX_SIDE = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW   = $clog2(MAX_SIDE + 1);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int NW   = DW + 1;
  localparam int AW   = 2 * DW;
  localparam int SUMW = SAMPLE_W + AW;

  // configuration registers
  logic [CFG_W-1:0] src_width, src_height, max_dim;
  logic             wide_samples;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width    <= CFG_W'(1);
      src_height   <= CFG_W'(1);
      max_dim      <= '0;
      wide_samples <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SRC_WIDTH:    src_width    <= cfg_data;
        REG_SRC_HEIGHT:   src_height   <= cfg_data;
        REG_MAX_DIM:      max_dim      <= cfg_data;
        REG_WIDE_SAMPLES: wide_samples <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [DW-1:0] w, h, longest;
  logic          need_div;

  always_comb begin
    if (src_width == '0) w = DW'(1);
    else if (int'(src_width) > MAX_WIDTH) w = DW'(MAX_WIDTH);
    else w = DW'(src_width);
    if (src_height == '0) h = DW'(1);
    else if (int'(src_height) > MAX_HEIGHT) h = DW'(MAX_HEIGHT);
    else h = DW'(src_height);
    longest  = (w > h) ? w : h;
    need_div = (max_dim != '0) && (int'(longest) > int'(max_dim));
  end

  // scale divider, one quotient bit a cycle
  logic [NW-1:0]    sq;
  logic [CFG_W-1:0] srem;
  logic [CFG_W:0]   srem_sh;
  logic             s_bit;

  assign srem_sh = {srem, sq[NW-1]};
  assign s_bit   = srem_sh >= {1'b0, max_dim};

  always_ff @(posedge clk) begin
    if (cmd.scale_init) begin
      sq   <= NW'(longest) + NW'(max_dim) - NW'(1);
      srem <= '0;
    end else if (cmd.scale_step) begin
      sq   <= {sq[NW-2:0], s_bit};
      srem <= s_bit ? CFG_W'(srem_sh - {1'b0, max_dim}) : srem_sh[CFG_W-1:0];
    end
  end

  // block scale and area
  logic [DW-1:0] s;
  logic [AW-1:0] area;

  always_ff @(posedge clk) begin
    if (rst) begin
      s    <= DW'(1);
      area <= AW'(1);
    end else begin
      if (cmd.scale_load) s <= need_div ? sq[DW-1:0] : DW'(1);
      if (cmd.area_load) area <= AW'(s) * AW'(s);
    end
  end

  // pixel latch with sample masking
  logic [SAMPLE_W-1:0] pix [3];

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      pix[0] <= wide_samples ? in_data.red_sample   : {8'd0, in_data.red_sample[7:0]};
      pix[1] <= wide_samples ? in_data.green_sample : {8'd0, in_data.green_sample[7:0]};
      pix[2] <= wide_samples ? in_data.blue_sample  : {8'd0, in_data.blue_sample[7:0]};
    end
  end

  // position counters
  logic [DW-1:0] col, row, ix, iy, bx, cs, rs;
  logic          col_end, row_end, ix_end, iy_end;
  logic [DW:0]   c_plus, r_plus;
  logic [DW+1:0] c_plus2, r_plus2;
  logic          c_last, r_last;

  always_comb begin
    col_end = ((DW+1)'(col) + (DW+1)'(1)) >= (DW+1)'(w);
    row_end = ((DW+1)'(row) + (DW+1)'(1)) >= (DW+1)'(h);
    ix_end  = ix == (s - DW'(1));
    iy_end  = iy == (s - DW'(1));
    c_plus  = (DW+1)'(cs) + (DW+1)'(s);
    r_plus  = (DW+1)'(rs) + (DW+1)'(s);
    c_plus2 = (DW+2)'(cs) + (DW+2)'({s, 1'b0});
    r_plus2 = (DW+2)'(rs) + (DW+2)'({s, 1'b0});
    c_last  = c_plus2 > (DW+2)'(w);
    r_last  = r_plus2 > (DW+2)'(h);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0; row <= '0; ix <= '0; iy <= '0;
      bx  <= '0; cs  <= '0; rs <= '0;
    end else if (cmd.upd) begin
      if (col_end) begin
        col <= '0; ix <= '0; bx <= '0; cs <= '0;
        if (row_end) begin
          row <= '0; iy <= '0; rs <= '0;
        end else begin
          row <= row + DW'(1);
          if (iy_end) begin
            iy <= '0;
            rs <= rs + s;
          end else begin
            iy <= iy + DW'(1);
          end
        end
      end else begin
        col <= col + DW'(1);
        if (ix_end) begin
          ix <= '0;
          bx <= bx + DW'(1);
          cs <= cs + s;
        end else begin
          ix <= ix + DW'(1);
        end
      end
    end
  end

  // line sum memory, one word holds three channels
  logic [3*SUMW-1:0] line_mem [MAX_WIDTH];
  logic [3*SUMW-1:0] rd_q, wr_word;
  logic [CW-1:0]     addr;
  logic [SUMW-1:0]   new_sum [3];
  logic              first;

  assign addr  = bx[CW-1:0];
  assign first = (ix == '0) && (iy == '0);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      new_sum[k] = first ? SUMW'(pix[k])
                         : rd_q[k*SUMW +: SUMW] + SUMW'(pix[k]);
    end
    wr_word = {new_sum[2], new_sum[1], new_sum[0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) rd_q <= line_mem[addr];
    if (cmd.upd && status.blk_ok) line_mem[addr] <= wr_word;
  end

  // sum divider by block area, three channels side by side
  logic [AW-1:0]     drem [3];
  logic [QUOT_W-1:0] dlow [3];
  logic [AW:0]       drem_sh [3];
  logic              d_bit [3];
  logic              fl_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      drem_sh[k] = {drem[k], dlow[k][QUOT_W-1]};
      d_bit[k]   = drem_sh[k] >= {1'b0, area};
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      if (cmd.div_init) begin
        drem[k] <= new_sum[k][SUMW-1:QUOT_W];
        dlow[k] <= new_sum[k][QUOT_W-1:0];
      end else if (cmd.div_step) begin
        dlow[k] <= {dlow[k][QUOT_W-2:0], d_bit[k]};
        drem[k] <= d_bit[k] ? AW'(drem_sh[k] - {1'b0, area}) : drem_sh[k][AW-1:0];
      end
    end
    if (cmd.div_init) fl_q <= c_last && r_last;
  end

  // quotient to byte: high byte for wide samples, else clamped to 255
  logic [7:0] byte_val [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (wide_samples) byte_val[k] = dlow[k][15:8];
      else if (dlow[k] > QUOT_W'(BYTE_MAX)) byte_val[k] = BYTE_MAX;
      else byte_val[k] = dlow[k][7:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.argb_pixel <= {ALPHA_OPAQUE, byte_val[0], byte_val[1], byte_val[2]};
      out_data.frame_last <= fl_q;
    end
  end

  // status to controller
  always_comb begin
    status.frame_start = (col == '0) && (row == '0);
    status.blk_ok      = (c_plus <= (DW+1)'(w)) && (r_plus <= (DW+1)'(h));
    status.blk_end     = ix_end && iy_end;
    status.out_free    = !out_valid || out_ready;
  end

endmodule
`default_nettype wire

FILE: test/rgb_box_downsampler_unit_tb.sv
// testbench for the rgb box downsampler: directed table and random frames
`timescale 1ns / 1ps
module rgb_box_downsampler_unit_tb import rbd_pkg::*;;

  localparam int LINE_MAX = 8192;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PIXELS = 1150;

  logic clk;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;

  rgb_box_downsampler_unit dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // pixel model state
  longint unsigned red_acc [LINE_MAX];
  longint unsigned green_acc [LINE_MAX];
  longint unsigned blue_acc [LINE_MAX];
  int unsigned pix_col, pix_row;
  longint unsigned scale_now, area_now;
  int unsigned width_reg, height_reg, maxdim_reg, wide_reg;

  out_item_t expected_pixels[$];
  int fail_count;
  int send_idle_pct, recv_stall_pct;

  // clock
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned clip_size(int unsigned v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic logic [7:0] average_byte(longint unsigned sum, longint unsigned area,
                                              bit wide);
    longint unsigned v;
    v = sum / area;
    if (wide) v = v >> 8;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  // advance the model by one source pixel
  task automatic model_pixel(input in_item_t px, output bit produced, output out_item_t res);
    int unsigned w, h, longest;
    bit wide;
    longint unsigned mask, r, g, b, dw, dh, bx, by, ix, iy;
    w = clip_size(width_reg, LINE_MAX);
    h = clip_size(height_reg, LINE_MAX);
    wide = wide_reg != 0;
    mask = wide ? 64'hFFFF : 64'hFF;
    r = px.red_sample & mask;
    g = px.green_sample & mask;
    b = px.blue_sample & mask;
    produced = 0;
    res = '0;
    // scale latches at frame start
    if (pix_col == 0 && pix_row == 0) begin
      longest = w > h ? w : h;
      scale_now = 1;
      if (maxdim_reg != 0 && longest > maxdim_reg)
        scale_now = (longest + maxdim_reg - 1) / maxdim_reg;
      area_now = scale_now * scale_now;
    end
    dw = w / scale_now;
    dh = h / scale_now;
    bx = pix_col / scale_now;
    by = pix_row / scale_now;
    ix = pix_col % scale_now;
    iy = pix_row % scale_now;
    if (bx < dw && by < dh && bx < LINE_MAX) begin
      if (ix == 0 && iy == 0) begin
        red_acc[bx] = r;
        green_acc[bx] = g;
        blue_acc[bx] = b;
      end else begin
        red_acc[bx] += r;
        green_acc[bx] += g;
        blue_acc[bx] += b;
      end
      if (ix == scale_now - 1 && iy == scale_now - 1) begin
        res.argb_pixel = {ALPHA_OPAQUE, average_byte(red_acc[bx], area_now, wide),
                          average_byte(green_acc[bx], area_now, wide),
                          average_byte(blue_acc[bx], area_now, wide)};
        res.frame_last = (bx == dw - 1 && by == dh - 1);
        produced = 1;
      end
    end
    // raster position
    if (pix_col + 1 >= w) begin
      pix_col = 0;
      pix_row = (pix_row + 1 >= h) ? 0 : pix_row + 1;
    end else begin
      pix_col = pix_col + 1;
    end
  endtask

  // drop valid, wait for every pending pixel, then let the block settle
  task automatic wait_drained();
    in_valid <= 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // one config beat, only while the block is idle
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_drained();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_SRC_WIDTH:    width_reg = 32'(val);
      REG_SRC_HEIGHT:   height_reg = 32'(val);
      REG_MAX_DIM:      maxdim_reg = 32'(val);
      REG_WIDE_SAMPLES: wide_reg = 32'(val[0]);
      default: ;
    endcase
  endtask

  // one pixel beat; typed overrides the model's expectation
  task automatic send_pixel(input in_item_t px, input bit typed, input out_item_t typed_res);
    bit produced;
    out_item_t res;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1;
    in_data <= px;
    do @(posedge clk); while (!in_ready);
    model_pixel(px, produced, res);
    if (typed) expected_pixels.push_back(typed_res);
    else if (produced) expected_pixels.push_back(res);
  endtask

  function automatic in_item_t random_pixel();
    in_item_t px;
    px.red_sample = 16'($urandom);
    px.green_sample = 16'($urandom);
    px.blue_sample = 16'($urandom);
    if ($urandom_range(7) == 0) px.red_sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    if ($urandom_range(7) == 0) px.blue_sample = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return px;
  endfunction

  // output beat checker and receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $error("unexpected output beat %h", out_data);
          fail_count++;
        end else begin
          out_item_t e;
          e = expected_pixels.pop_front();
          if (out_data.argb_pixel !== e.argb_pixel) begin
            $error("argb_pixel expected %h actual %h", e.argb_pixel, out_data.argb_pixel);
            fail_count++;
          end
          if (out_data.frame_last !== e.frame_last) begin
            $error("frame_last expected %b actual %b", e.frame_last, out_data.frame_last);
            fail_count++;
          end
        end
      end
    end
    out_ready <= !rst && !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  typedef struct {
    bit is_cfg;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] val;
    in_item_t px;
    bit typed;
    out_item_t res;
  } step_row_t;

  localparam out_item_t NONE = '0;

  // directed table
  step_row_t directed [] = '{
    // reset state: 1x1 frames, 8-bit samples
    '{0, REG_SRC_WIDTH, 0, '{16'h0000, 16'h0000, 16'h0000}, 1, '{32'hFF000000, 1'b1}},
    '{0, REG_SRC_WIDTH, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{32'hFFFFFFFF, 1'b1}},
    '{0, REG_SRC_WIDTH, 0, '{16'h1234, 16'hABCD, 16'h00FF}, 1, '{32'hFF34CDFF, 1'b1}},
    // 16-bit samples keep the high byte
    '{1, REG_WIDE_SAMPLES, 1, '{0, 0, 0}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{32'hFFFFFFFF, 1'b1}},
    '{0, REG_SRC_WIDTH, 0, '{16'h8000, 16'h00FF, 16'h0100}, 1, '{32'hFF800001, 1'b1}},
    // 2x2 frame with max side 1: one 2x2 block
    '{1, REG_SRC_WIDTH, 2, '{0, 0, 0}, 0, NONE},
    '{1, REG_SRC_HEIGHT, 2, '{0, 0, 0}, 0, NONE},
    '{1, REG_MAX_DIM, 1, '{0, 0, 0}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1, '{32'hFFFFFFFF, 1'b1}},
    // zero sizes act as 1, max side at its top
    '{1, REG_WIDE_SAMPLES, 0, '{0, 0, 0}, 0, NONE},
    '{1, REG_SRC_WIDTH, 0, '{0, 0, 0}, 0, NONE},
    '{1, REG_SRC_HEIGHT, 0, '{0, 0, 0}, 0, NONE},
    '{1, REG_MAX_DIM, 14'h3FFF, '{0, 0, 0}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'h00AB, 16'h01CD, 16'hFFEF}, 1, '{32'hFFABCDEF, 1'b1}},
    // 3x2 with max side 1: scale 3 beyond the height, no full block
    '{1, REG_SRC_WIDTH, 3, '{0, 0, 0}, 0, NONE},
    '{1, REG_SRC_HEIGHT, 2, '{0, 0, 0}, 0, NONE},
    '{1, REG_MAX_DIM, 1, '{0, 0, 0}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'h1111, 16'h2222, 16'h3333}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'h4444, 16'h5555, 16'h6666}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'h7777, 16'h8888, 16'h9999}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'hAAAA, 16'hBBBB, 16'hCCCC}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'hDDDD, 16'hEEEE, 16'hFFFF}, 0, NONE},
    '{0, REG_SRC_WIDTH, 0, '{16'h0001, 16'h0080, 16'h8000}, 0, NONE}
  };

  // stimulus
  initial begin
    logic [IDX_W-1:0] reg_order [4];
    logic [CFG_W-1:0] reg_val [4];
    int unsigned sent, phase_sent, mode, first, n, pick;
    reg_order = '{REG_SRC_WIDTH, REG_SRC_HEIGHT, REG_MAX_DIM, REG_WIDE_SAMPLES};
    rst = 1;
    cfg_valid = 0;
    cfg_index = REG_SRC_WIDTH;
    cfg_data = '0;
    in_valid = 0;
    in_data = '0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    pix_col = 0;
    pix_row = 0;
    scale_now = 1;
    area_now = 1;
    width_reg = 1;
    height_reg = 1;
    maxdim_reg = 0;
    wide_reg = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    foreach (directed[i]) begin
      if (directed[i].is_cfg) write_reg(directed[i].idx, directed[i].val);
      else send_pixel(directed[i].px, directed[i].typed, directed[i].res);
    end

    // random frames in idling phases
    sent = 0;
    phase_sent = 0;
    mode = 0;
    while (sent < RANDOM_PIXELS) begin
      if (phase_sent > RANDOM_PIXELS / 4) begin
        phase_sent = 0;
        mode = (mode + 1) % 4;
        // hold off until the pipe is empty before the new phase
        wait_drained();
      end
      send_idle_pct = (mode == 1 || mode == 3) ? (mode == 1 ? 69 : 24) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 69 : 24) : 0;
      reg_val[0] = CFG_W'($urandom_range(15) == 0 ? 0 : $urandom_range(1, 14));
      reg_val[1] = CFG_W'($urandom_range(15) == 0 ? 0 : $urandom_range(1, 14));
      pick = $urandom_range(7);
      reg_val[2] = pick == 0 ? '0 : (pick == 1 ? 14'h3FFF : CFG_W'($urandom_range(1, 12)));
      reg_val[3] = CFG_W'($urandom_range(1));
      first = $urandom_range(3);
      for (int k = 0; k < 4; k++) write_reg(reg_order[(first + k) % 4], reg_val[(first + k) % 4]);
      n = clip_size(32'(reg_val[0]), LINE_MAX) * clip_size(32'(reg_val[1]), LINE_MAX);
      repeat (n) send_pixel(random_pixel(), 0, NONE);
      sent += n;
      phase_sent += n;
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/rbd_pkg.sv
rtl/rbd_ctrl.sv
rtl/rbd_datapath.sv
rtl/rgb_box_downsampler_unit.sv
test/rgb_box_downsampler_unit_tb.sv
